FILE: rtl/lba_to_chs_track_splitter_core_defines.svh
// assertion macros shared by the checker of the track splitter
`ifndef LBA_TO_CHS_TRACK_SPLITTER_CORE_DEFINES_SVH
`define LBA_TO_CHS_TRACK_SPLITTER_CORE_DEFINES_SVH

// property checked on every clock edge outside reset
`define LCS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define LCS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/lbachs_pkg.sv
// types and constants of the logical-sector to cylinder/head/sector splitter
package lbachs_pkg;

    // request item
    typedef struct packed {
        logic [7:0]  drive;
        logic [31:0] start_sector;
        logic [5:0]  sector_count;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [7:0] cylinder_low;
        logic [7:0] sector_and_cyl_high;
        logic [7:0] head;
        logic [7:0] drive_out;
        logic [5:0] chunk_sectors;
        logic [5:0] buffer_offset;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_GEOM = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SPT   = 2'd0;
    localparam logic [1:0] CFG_HEADS = 2'd1;
    localparam logic [1:0] CFG_CYLS  = 2'd2;

    // geometry reset values and addressing limit
    localparam logic [5:0]  SPT_RESET   = 6'd63;
    localparam logic [8:0]  HEADS_RESET = 9'd16;
    localparam logic [10:0] CYLS_RESET  = 11'd1024;
    localparam logic [10:0] CYL_LIMIT   = 11'd1024;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_TRK,
        ST_DIV_CYL,
        ST_EMIT,
        ST_BAD
    } t_state;

endpackage

FILE: rtl/lba_to_chs_track_splitter_core.sv
// splits a sector read request into track-bounded cylinder/head/sector chunks
//
// Request channel (i_in_valid/o_in_ready, i_in_item): drive, first logical
// sector and sector count. Result channel (o_out_valid/i_out_ready,
// o_out_item): one item per track-bounded chunk, last set on the final one.
// Configuration channel (i_cfg_valid/o_cfg_ready, index 0 sectors per track,
// 1 heads, 2 cylinders) is ready outside reset; it is to be written between
// requests, which the block itself does not enforce. A request with valid
// geometry and a count above zero is accepted, runs the bit-serial
// sector/track divide and then the track/head divide, then gives one chunk
// per cycle while the receiver takes them. The single shared restoring
// divider gives one quotient bit per cycle for both divides. Zero sectors
// or heads gives one bad-geometry item; a zero count with good geometry
// gives nothing and the block is ready again at once.
// Results pass through an output register, so the next request is taken
// while the final item of the previous one still waits; when the receiver
// stalls, chunk generation holds. Reset empties the output register, returns
// the sequencer to idle and loads the geometry with 63 sectors, 16 heads and
// 1024 cylinders.
module lba_to_chs_track_splitter_core
    import lbachs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    t_state      r_state, n_state;
    logic [4:0]  r_cnt;
    logic [31:0] r_dvd;
    logic [8:0]  r_rem;
    logic [5:0]  r_spt;
    logic [8:0]  r_heads;
    logic [10:0] r_cyls;
    logic [7:0]  r_drive;
    logic [5:0]  r_remain;
    logic [5:0]  r_offs;
    logic [5:0]  r_idx;
    logic [8:0]  r_head;
    logic [10:0] r_cyl;
    t_out_item   r_out;
    logic        r_out_valid;

    logic        w_accept, w_bad_geom, w_slot, w_emit, w_div_done;
    logic [8:0]  w_divisor;
    logic [9:0]  w_part, w_diff;
    logic        w_ge;
    logic [8:0]  n_rem;
    logic [31:0] n_dvd;
    logic [5:0]  w_room, w_chunk, w_left;
    logic        w_fail, w_wrap;
    logic [8:0]  w_head_inc;
    logic [10:0] w_cyl_inc;
    t_out_item   w_result;

    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_bad_geom = (r_spt == 6'd0) || (r_heads == 9'd0);
    assign w_slot     = !r_out_valid || i_out_ready;
    assign w_div_done = (r_cnt == 5'd31);

    // shared restoring divider step, one quotient bit per cycle
    always_comb begin
        w_divisor = (r_state == ST_DIV_TRK) ? {3'd0, r_spt} : r_heads;
        w_part    = {r_rem, r_dvd[31]};
        w_diff    = w_part - {1'b0, w_divisor};
        w_ge      = (w_part >= {1'b0, w_divisor});
        n_rem     = w_ge ? w_diff[8:0] : w_part[8:0];
        n_dvd     = {r_dvd[30:0], w_ge};
    end

    // chunk size, range check and next track position
    always_comb begin
        w_room     = r_spt - r_idx;
        w_chunk    = (r_remain < w_room) ? r_remain : w_room;
        w_left     = r_remain - w_chunk;
        w_fail     = (r_cyl >= r_cyls) || (r_cyl >= CYL_LIMIT) || r_head[8];
        w_head_inc = r_head + 9'd1;
        w_wrap     = (w_head_inc == r_heads);
        w_cyl_inc  = (r_cyl >= CYL_LIMIT) ? r_cyl : r_cyl + 11'd1;
    end

    // result item
    always_comb begin
        w_result           = '0;
        w_result.drive_out = r_drive;
        w_result.last      = 1'b1;
        if (r_state == ST_BAD) begin
            w_result.status = STATUS_BAD_GEOM;
        end else if (w_fail) begin
            w_result.status        = STATUS_RANGE;
            w_result.buffer_offset = r_offs;
        end else begin
            w_result.cylinder_low        = r_cyl[7:0];
            w_result.sector_and_cyl_high = {r_cyl[9:8], r_idx + 6'd1};
            w_result.head                = r_head[7:0];
            w_result.chunk_sectors       = w_chunk;
            w_result.buffer_offset       = r_offs;
            w_result.status              = STATUS_OK;
            w_result.last                = (w_left == 6'd0);
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_bad_geom) begin
                        n_state = ST_BAD;
                    end else if (i_in_item.sector_count != 6'd0) begin
                        n_state = ST_DIV_TRK;
                    end
                end
            end
            ST_DIV_TRK: begin
                if (w_div_done) n_state = ST_DIV_CYL;
            end
            ST_DIV_CYL: begin
                if (w_div_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_slot && (w_fail || w_left == 6'd0)) n_state = ST_IDLE;
            end
            ST_BAD: begin
                if (w_slot) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = i_rst_n && (r_state == ST_IDLE);
        w_emit     = ((r_state == ST_EMIT) || (r_state == ST_BAD)) && w_slot;
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_spt       <= SPT_RESET;
            r_heads     <= HEADS_RESET;
            r_cyls      <= CYLS_RESET;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SPT:   r_spt   <= i_cfg_data[5:0];
                    CFG_HEADS: r_heads <= i_cfg_data[8:0];
                    CFG_CYLS:  r_cyls  <= i_cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        if (w_emit) r_out <= w_result;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_drive  <= i_in_item.drive;
                    r_dvd    <= i_in_item.start_sector;
                    r_remain <= i_in_item.sector_count;
                    r_offs   <= 6'd0;
                    r_rem    <= 9'd0;
                    r_cnt    <= 5'd0;
                end
            end
            ST_DIV_TRK: begin
                r_dvd <= n_dvd;
                r_cnt <= r_cnt + 5'd1;
                if (w_div_done) begin
                    r_idx <= n_rem[5:0];
                    r_rem <= 9'd0;
                end else begin
                    r_rem <= n_rem;
                end
            end
            ST_DIV_CYL: begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 5'd1;
                if (w_div_done) begin
                    r_head <= n_rem;
                    r_cyl  <= (|n_dvd[31:10]) ? CYL_LIMIT : {1'b0, n_dvd[9:0]};
                end
            end
            ST_EMIT: begin
                if (w_slot && !w_fail) begin
                    r_remain <= w_left;
                    r_offs   <= r_offs + w_chunk;
                    r_idx    <= 6'd0;
                    if (w_wrap) begin
                        r_head <= 9'd0;
                        r_cyl  <= w_cyl_inc;
                    end else begin
                        r_head <= w_head_inc;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/lbachs_checker.sv
// port checker for the track splitter, bound to the top level
`include "lba_to_chs_track_splitter_core_defines.svh"

module lbachs_checker
    import lbachs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in_item    i_in_item,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_item,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [10:0] i_cfg_data
);

    // a pending item is held until taken
    `LCS_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result item dropped")

    // reset empties the result register
    `LCS_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid, "result item after reset")

    // error items always end their request
    `LCS_ASSERT(a_err_last, o_out_valid && o_out_item.status != STATUS_OK |-> o_out_item.last, "error item not last")

    // a good chunk carries sectors and a sector number of one or more
    `LCS_ASSERT(a_chunk_nonzero, o_out_valid && o_out_item.status == STATUS_OK |-> o_out_item.chunk_sectors != 6'd0 && o_out_item.sector_and_cyl_high[5:0] != 6'd0, "empty chunk")

endmodule

bind lba_to_chs_track_splitter_core lbachs_checker u_lbachs_checker (.*);
